[hw/rtl/quadrature_count_velocity_ema_macros.svh]
// Assertion macros used by the encoder counter RTL
`ifndef QUADRATURE_COUNT_VELOCITY_EMA_MACROS_SVH
`define QUADRATURE_COUNT_VELOCITY_EMA_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define QCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define QCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qcv_pkg.sv]
// Shared constants, types and helpers for the quadrature counter with velocity averaging
`default_nettype none

package qcv_pkg;

  // Counter and timestamp widths
  localparam int COUNT_BITS = 32;
  localparam int TIME_BITS  = 32;

  // Port field widths
  localparam int KIND_W    = 2;
  localparam int STAMP_W   = 32;
  localparam int POS_W     = 32;
  localparam int VEL_W     = 32;
  localparam int MPC_W     = 32;
  localparam int ALPHA_W   = 17;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Speed arithmetic sizes
  localparam int FRAC_W     = 16;
  localparam int USEC_W     = 20;
  localparam int K_W        = MPC_W + USEC_W;
  localparam int PROD_W     = COUNT_BITS + K_W;
  localparam int QUO_W      = 32;
  localparam int HI_W       = PROD_W - QUO_W;
  localparam int D_W        = TIME_BITS + FRAC_W;
  localparam int CMP_W      = (HI_W > D_W) ? HI_W : D_W;
  localparam int STEP_MAX   = (COUNT_BITS > QUO_W) ? COUNT_BITS : QUO_W;
  localparam int STEP_W     = $clog2(STEP_MAX);
  localparam int DIFF_W     = VEL_W + 1;
  localparam int EMA_PROD_W = DIFF_W + ALPHA_W + 1;

  localparam logic [USEC_W-1:0]    USEC_PER_SEC = USEC_W'(1000000);
  localparam logic [TIME_BITS-1:0] MIN_DT       = TIME_BITS'(1000);
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE    = ALPHA_W'(65536);
  localparam logic [STEP_W-1:0]    MUL_LAST     = STEP_W'(COUNT_BITS - 1);
  localparam logic [STEP_W-1:0]    DIV_LAST     = STEP_W'(QUO_W - 1);
  localparam logic [VEL_W-1:0]     SAT_POS      = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0]     SAT_NEG      = {1'b1, {(VEL_W-1){1'b0}}};

  // Register defaults
  localparam logic [MPC_W-1:0]   MPC_RESET   = MPC_W'(1000000);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(19661);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_EDGE_A = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_EDGE_B = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_SAMPLE = KIND_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MPC    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = CFG_IDX_W'(2);

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPEED,
    ST_EMA_ADD
  } state_t;

  // Speed engine sequencer
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_CHK,
    ENG_DIV,
    ENG_SAT,
    ENG_DONE
  } eng_state_t;

  // Request from the top level to the speed engine
  typedef struct packed {
    logic                  start;
    logic                  neg;
    logic [COUNT_BITS-1:0] mag;
    logic [TIME_BITS-1:0]  dt;
    logic [MPC_W-1:0]      mpc;
  } speed_req_t;

  // Answer from the speed engine
  typedef struct packed {
    logic             done;
    logic [VEL_W-1:0] raw;
  } speed_rsp_t;

  // Negate a reported value when direction is inverted
  function automatic logic [POS_W-1:0] apply_sign(input logic inv, input logic [POS_W-1:0] v);
    return inv ? (POS_W'(0) - v) : v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qcv_speed.sv]
// Bit-serial speed engine: count delta times travel scale, divided by elapsed time
`default_nettype none

module qcv_speed (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qcv_pkg::speed_req_t req,
  output qcv_pkg::speed_rsp_t      rsp
);

  qcv_pkg::eng_state_t state, state_next;

  logic [qcv_pkg::STEP_W-1:0] cnt;
  logic [qcv_pkg::PROD_W-1:0] prod;
  logic [qcv_pkg::K_W-1:0]    kreg;
  logic [qcv_pkg::D_W-1:0]    dreg;
  logic                       neg;
  logic                       ovf;
  logic [qcv_pkg::D_W-1:0]    rem;
  logic [qcv_pkg::QUO_W-1:0]  quo;
  logic [qcv_pkg::VEL_W-1:0]  raw;

  logic [qcv_pkg::K_W:0]      msum;
  logic [qcv_pkg::HI_W-1:0]   hi;
  logic                       ovf_now;
  logic [qcv_pkg::D_W:0]      r2;
  logic [qcv_pkg::D_W:0]      rdiff;
  logic                       ge;
  logic [qcv_pkg::VEL_W-1:0]  raw_next;

  // Multiply step: add scale to the upper half when the low bit is set, shift right
  assign msum = {1'b0, prod[qcv_pkg::PROD_W-1:qcv_pkg::COUNT_BITS]} + {1'b0, kreg};

  // Quotient overflow check on the top of the product
  assign hi      = prod[qcv_pkg::PROD_W-1:qcv_pkg::QUO_W];
  assign ovf_now = qcv_pkg::CMP_W'(hi) >= qcv_pkg::CMP_W'(dreg);

  // Restoring divide step: one quotient bit per cycle
  assign r2    = {rem, quo[qcv_pkg::QUO_W-1]};
  assign rdiff = r2 - {1'b0, dreg};
  assign ge    = r2 >= {1'b0, dreg};

  // Saturate the magnitude and apply the sign
  always_comb begin
    if (neg) begin
      if (ovf || (quo > qcv_pkg::SAT_NEG)) begin
        raw_next = qcv_pkg::SAT_NEG;
      end else begin
        raw_next = qcv_pkg::VEL_W'(0) - qcv_pkg::VEL_W'(quo);
      end
    end else begin
      if (ovf || quo[qcv_pkg::QUO_W-1]) begin
        raw_next = qcv_pkg::SAT_POS;
      end else begin
        raw_next = qcv_pkg::VEL_W'(quo);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      qcv_pkg::ENG_IDLE: begin
        if (req.start) state_next = qcv_pkg::ENG_MUL;
      end
      qcv_pkg::ENG_MUL: begin
        if (cnt == qcv_pkg::MUL_LAST) state_next = qcv_pkg::ENG_CHK;
      end
      qcv_pkg::ENG_CHK: begin
        state_next = ovf_now ? qcv_pkg::ENG_SAT : qcv_pkg::ENG_DIV;
      end
      qcv_pkg::ENG_DIV: begin
        if (cnt == qcv_pkg::DIV_LAST) state_next = qcv_pkg::ENG_SAT;
      end
      qcv_pkg::ENG_SAT:  state_next = qcv_pkg::ENG_DONE;
      qcv_pkg::ENG_DONE: state_next = qcv_pkg::ENG_IDLE;
      default:           state_next = qcv_pkg::ENG_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp.done = (state == qcv_pkg::ENG_DONE);
    rsp.raw  = raw;
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qcv_pkg::ENG_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == qcv_pkg::ENG_MUL) || (state == qcv_pkg::ENG_DIV)) begin
        cnt <= cnt + qcv_pkg::STEP_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      qcv_pkg::ENG_IDLE: begin
        if (req.start) begin
          prod <= qcv_pkg::PROD_W'(req.mag);
          kreg <= qcv_pkg::K_W'(req.mpc) * qcv_pkg::K_W'(qcv_pkg::USEC_PER_SEC);
          dreg <= {req.dt, {qcv_pkg::FRAC_W{1'b0}}};
          neg  <= req.neg;
        end
      end
      qcv_pkg::ENG_MUL: begin
        if (prod[0]) begin
          prod <= {msum, prod[qcv_pkg::COUNT_BITS-1:1]};
        end else begin
          prod <= {1'b0, prod[qcv_pkg::PROD_W-1:1]};
        end
      end
      qcv_pkg::ENG_CHK: begin
        ovf <= ovf_now;
        rem <= qcv_pkg::D_W'(hi);
        quo <= prod[qcv_pkg::QUO_W-1:0];
      end
      qcv_pkg::ENG_DIV: begin
        rem <= ge ? rdiff[qcv_pkg::D_W-1:0] : r2[qcv_pkg::D_W-1:0];
        quo <= {quo[qcv_pkg::QUO_W-2:0], ge};
      end
      qcv_pkg::ENG_SAT: begin
        raw <= raw_next;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/quadrature_count_velocity_ema.sv]
// Edge, unknown and non-computing sample items: the result is registered as pending, then moved
// to the output register when that is free; the input stays stalled until it has moved out.
// Speed samples: a bit-serial multiply, an overflow check and a restoring divide (skipped on
// quotient overflow), then saturation; a seed goes straight to the result, while an average
// passes through the add state first. The next item is taken only after the result moves out.
// Synchronous active-high reset clears count, sample history and average, loads defaults.
`default_nettype none
`include "quadrature_count_velocity_ema_macros.svh"

module quadrature_count_velocity_ema (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [qcv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qcv_pkg::CFG_W-1:0]       cfg_data,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [qcv_pkg::KIND_W-1:0]      kind,
  input  wire logic                            level_a,
  input  wire logic                            level_b,
  input  wire logic [qcv_pkg::STAMP_W-1:0]     now_us,
  // output channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [qcv_pkg::POS_W-1:0]     position,
  output logic signed [qcv_pkg::VEL_W-1:0]     velocity,
  output logic                                 is_sample
);

  qcv_pkg::state_t state, state_next;

  // Configuration
  logic                          invert_direction;
  logic [qcv_pkg::MPC_W-1:0]     metres_per_count;
  logic [qcv_pkg::ALPHA_W-1:0]   smoothing_alpha;

  // Tracking state
  logic [qcv_pkg::COUNT_BITS-1:0] position_count;
  logic [qcv_pkg::COUNT_BITS-1:0] previous_count;
  logic [qcv_pkg::TIME_BITS-1:0]  previous_time;
  logic                           awaiting_first_sample;
  logic                           average_seeded;
  logic [qcv_pkg::VEL_W-1:0]      filtered_speed;

  // Pending result and output register
  logic                           res_valid;
  logic [qcv_pkg::POS_W-1:0]      res_position;
  logic [qcv_pkg::VEL_W-1:0]      res_velocity;
  logic                           res_is_sample;
  logic                           move;

  logic signed [qcv_pkg::EMA_PROD_W-1:0] ema_prod;

  qcv_pkg::speed_req_t spd_req;
  qcv_pkg::speed_rsp_t spd_rsp;

  logic                           accept;
  logic                           levels_eq;
  logic [qcv_pkg::TIME_BITS-1:0]  stamp;
  logic [qcv_pkg::TIME_BITS-1:0]  dt;
  logic                           too_early;
  logic                           run_speed;
  logic [qcv_pkg::COUNT_BITS-1:0] delta;
  logic [qcv_pkg::COUNT_BITS-1:0] count_next;
  logic [qcv_pkg::ALPHA_W-1:0]    alpha_sat;
  logic [qcv_pkg::DIFF_W-1:0]     ema_diff;
  logic [qcv_pkg::VEL_W-1:0]      filtered_next;
  logic                           seed_now;

  assign accept    = in_valid && !in_stall;
  assign levels_eq = (level_a == level_b);
  assign stamp     = qcv_pkg::TIME_BITS'(now_us);
  assign dt        = stamp - previous_time;
  assign too_early = dt < qcv_pkg::MIN_DT;
  assign run_speed = (kind == qcv_pkg::KIND_SAMPLE) && !too_early && !awaiting_first_sample;
  assign delta     = position_count - previous_count;

  // Count step for edge items
  always_comb begin
    case (kind)
      qcv_pkg::KIND_EDGE_A: count_next = levels_eq ? position_count - 1'b1
                                                   : position_count + 1'b1;
      qcv_pkg::KIND_EDGE_B: count_next = levels_eq ? position_count + 1'b1
                                                   : position_count - 1'b1;
      default:              count_next = position_count;
    endcase
  end

  // Averaging: filtered + floor(alpha * (raw - filtered) / 2^16)
  assign alpha_sat     = (smoothing_alpha > qcv_pkg::ALPHA_ONE) ? qcv_pkg::ALPHA_ONE
                                                                : smoothing_alpha;
  assign ema_diff      = {spd_rsp.raw[qcv_pkg::VEL_W-1], spd_rsp.raw}
                       - {filtered_speed[qcv_pkg::VEL_W-1], filtered_speed};
  assign filtered_next = filtered_speed
                       + ema_prod[qcv_pkg::FRAC_W+qcv_pkg::VEL_W-1:qcv_pkg::FRAC_W];
  assign seed_now      = !average_seeded && (spd_rsp.raw != '0);

  // Speed request
  always_comb begin
    spd_req.start = accept && run_speed;
    spd_req.neg   = delta[qcv_pkg::COUNT_BITS-1];
    spd_req.mag   = spd_req.neg ? (qcv_pkg::COUNT_BITS'(0) - delta) : delta;
    spd_req.dt    = dt;
    spd_req.mpc   = metres_per_count;
  end

  qcv_speed u_speed (
    .clk (clk),
    .rst (rst),
    .req (spd_req),
    .rsp (spd_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      qcv_pkg::ST_IDLE: begin
        if (accept && run_speed) state_next = qcv_pkg::ST_SPEED;
      end
      qcv_pkg::ST_SPEED: begin
        if (spd_rsp.done) state_next = seed_now ? qcv_pkg::ST_IDLE : qcv_pkg::ST_EMA_ADD;
      end
      qcv_pkg::ST_EMA_ADD: state_next = qcv_pkg::ST_IDLE;
      default:             state_next = qcv_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = (state != qcv_pkg::ST_IDLE) || res_valid;
  end

  // Move the pending result into the output register when it is free
  assign move = res_valid && (!out_valid || !out_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_direction <= 1'b0;
      metres_per_count <= qcv_pkg::MPC_RESET;
      smoothing_alpha  <= qcv_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qcv_pkg::REG_INVERT: invert_direction <= cfg_data[0];
        qcv_pkg::REG_MPC:    metres_per_count <= qcv_pkg::MPC_W'(cfg_data);
        qcv_pkg::REG_ALPHA:  smoothing_alpha  <= cfg_data[qcv_pkg::ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= qcv_pkg::ST_IDLE;
      res_valid             <= 1'b0;
      out_valid             <= 1'b0;
      position_count        <= '0;
      previous_count        <= '0;
      previous_time         <= '0;
      awaiting_first_sample <= 1'b1;
      average_seeded        <= 1'b0;
      filtered_speed        <= '0;
    end else begin
      state     <= state_next;
      out_valid <= move || (out_valid && out_stall);

      // hold the pending result until it moves; set it when an item finishes
      if (move) begin
        res_valid <= 1'b0;
      end else if (state == qcv_pkg::ST_IDLE && accept && !run_speed) begin
        res_valid <= 1'b1;
      end else if (state == qcv_pkg::ST_SPEED && spd_rsp.done && seed_now) begin
        res_valid <= 1'b1;
      end else if (state == qcv_pkg::ST_EMA_ADD) begin
        res_valid <= 1'b1;
      end

      // advance the count and record sample history
      if (accept) begin
        position_count <= count_next;
        if (kind == qcv_pkg::KIND_SAMPLE && !too_early) begin
          previous_count        <= position_count;
          previous_time         <= stamp;
          awaiting_first_sample <= 1'b0;
        end
      end

      // seed or update the average
      if (state == qcv_pkg::ST_SPEED && spd_rsp.done && seed_now) begin
        filtered_speed <= spd_rsp.raw;
        average_seeded <= 1'b1;
      end else if (state == qcv_pkg::ST_EMA_ADD) begin
        filtered_speed <= filtered_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_position  <= qcv_pkg::apply_sign(invert_direction, qcv_pkg::POS_W'(count_next));
      res_velocity  <= '0;
      res_is_sample <= (kind == qcv_pkg::KIND_SAMPLE);
    end else if (state == qcv_pkg::ST_SPEED && spd_rsp.done && seed_now) begin
      res_velocity <= qcv_pkg::apply_sign(invert_direction, spd_rsp.raw);
    end else if (state == qcv_pkg::ST_EMA_ADD) begin
      res_velocity <= qcv_pkg::apply_sign(invert_direction, filtered_next);
    end

    if (state == qcv_pkg::ST_SPEED && spd_rsp.done) begin
      ema_prod <= qcv_pkg::EMA_PROD_W'($signed(ema_diff) * $signed({1'b0, alpha_sat}));
    end

    if (move) begin
      position  <= res_position;
      velocity  <= res_velocity;
      is_sample <= res_is_sample;
    end
  end

  // Checks
  `QCV_ASSERT_NOW(a_pending_blocks_input, res_valid, in_stall, "input over pending result")
  `QCV_ASSERT_NOW(a_done_while_waiting, spd_rsp.done, state == qcv_pkg::ST_SPEED, "stray done")
  `QCV_ASSERT_NEXT(a_average_gives_result, state == qcv_pkg::ST_EMA_ADD, res_valid, "no result")
  `QCV_ASSERT_NEXT(a_first_flag_stays_clear, !awaiting_first_sample, !awaiting_first_sample, "flag")

endmodule

`default_nettype wire

[verif/quadrature_count_velocity_ema_tb.sv]
// Self-checking testbench for the x4 quadrature counter with averaged velocity
`timescale 1ns / 1ps

module quadrature_count_velocity_ema_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD = 400;
  localparam logic [qcv_pkg::KIND_W-1:0] KIND_UNUSED = qcv_pkg::KIND_W'(3);
  localparam logic [31:0] SAMPLE_MIN_GAP = 32'd1000;
  localparam logic [31:0] MICROS_PER_SECOND = 32'd1000000;
  localparam longint Q16_ONE = 65536;

  typedef struct packed {
    logic [qcv_pkg::POS_W-1:0] position;
    logic [qcv_pkg::VEL_W-1:0] velocity;
    logic                      is_sample;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    row_op_t                       op;
    logic [qcv_pkg::KIND_W-1:0]    kind;
    logic                          lev_a;
    logic                          lev_b;
    logic [qcv_pkg::STAMP_W-1:0]   stamp;
    bit                            typed;
    reading_t                      known;
    logic [qcv_pkg::CFG_IDX_W-1:0] reg_index;
    logic [qcv_pkg::CFG_W-1:0]     reg_value;
  } stim_row_t;

  // DUT signals
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [qcv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qcv_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [qcv_pkg::KIND_W-1:0] kind = '0;
  logic level_a = 1'b0;
  logic level_b = 1'b0;
  logic [qcv_pkg::STAMP_W-1:0] now_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [qcv_pkg::POS_W-1:0] position;
  logic signed [qcv_pkg::VEL_W-1:0] velocity;
  logic is_sample;

  // Predictor state and register copies
  logic [31:0] count_now = '0;
  logic [31:0] count_at_sample = '0;
  logic [31:0] stamp_at_sample = '0;
  logic awaiting_first = 1'b1;
  logic avg_seeded = 1'b0;
  longint avg_speed = 0;
  logic invert_reg = 1'b0;
  logic [31:0] mpc_reg = 32'd1000000;
  logic [16:0] alpha_reg = 17'd19661;

  reading_t pending_readings[$];
  stim_row_t directed_rows[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [31:0] stamp = '0;
  logic pin_a = 1'b0;
  logic pin_b = 1'b0;

  quadrature_count_velocity_ema dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .level_a   (level_a),
    .level_b   (level_b),
    .now_us    (now_us),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .velocity  (velocity),
    .is_sample (is_sample)
  );

  always #4 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive receiver stall: a long hold on request, else random per phase
  always @(negedge clk) begin
    if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Compare each output transaction with the oldest predicted reading
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading pos=%h vel=%h smp=%b", $time, position,
                 velocity, is_sample);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_readings.pop_front();
        if (position !== want.position) begin
          $display("%0t: position expected %h actual %h", $time, want.position, position);
          mismatch_count = mismatch_count + 1;
        end
        if (velocity !== want.velocity) begin
          $display("%0t: velocity expected %h actual %h", $time, want.velocity, velocity);
          mismatch_count = mismatch_count + 1;
        end
        if (is_sample !== want.is_sample) begin
          $display("%0t: is_sample expected %b actual %b", $time, want.is_sample, is_sample);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Advance the predicted count and velocity average by one transaction
  function automatic reading_t predict_reading(input logic [qcv_pkg::KIND_W-1:0] k,
                                               input logic la, input logic lb,
                                               input logic [31:0] now);
    reading_t r;
    logic [31:0] dt;
    logic [31:0] delta;
    logic [31:0] mag;
    logic [127:0] quotient;
    logic [127:0] cap;
    longint raw;
    longint weight;
    longint acc;
    r.velocity = '0;
    r.is_sample = (k == qcv_pkg::KIND_SAMPLE);
    case (k)
      qcv_pkg::KIND_EDGE_A: count_now = (la == lb) ? count_now - 32'd1 : count_now + 32'd1;
      qcv_pkg::KIND_EDGE_B: count_now = (la == lb) ? count_now + 32'd1 : count_now - 32'd1;
      qcv_pkg::KIND_SAMPLE: begin
        dt = now - stamp_at_sample;
        if (dt >= SAMPLE_MIN_GAP) begin
          if (awaiting_first) begin
            awaiting_first = 1'b0;
          end else begin
            // Speed in Q16.16: delta * metres per count * 1e6 / dt, then saturate
            delta = count_now - count_at_sample;
            mag = delta[31] ? 32'd0 - delta : delta;
            quotient = (128'(mag) * 128'(mpc_reg) * 128'(MICROS_PER_SECOND)) / 128'(dt);
            quotient = quotient >> 16;
            cap = delta[31] ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (quotient > cap) quotient = cap;
            raw = delta[31] ? -longint'(quotient[63:0]) : longint'(quotient[63:0]);
            // Seed the average on the first nonzero speed, else blend with floor
            if (!avg_seeded && raw != 0) begin
              avg_speed = raw;
              avg_seeded = 1'b1;
            end else begin
              weight = (alpha_reg > 17'd65536) ? Q16_ONE : longint'(alpha_reg);
              acc = (Q16_ONE - weight) * avg_speed + weight * raw;
              avg_speed = acc >>> 16;
            end
            r.velocity = avg_speed[31:0];
          end
          count_at_sample = count_now;
          stamp_at_sample = now;
        end
      end
      default: ;
    endcase
    r.position = count_now;
    if (invert_reg) begin
      r.position = 32'd0 - r.position;
      r.velocity = 32'd0 - r.velocity;
    end
    return r;
  endfunction

  // Offer one input transaction and record its predicted reading on acceptance
  task automatic offer_transaction(input logic [qcv_pkg::KIND_W-1:0] k, input logic la,
                                   input logic lb, input logic [31:0] now,
                                   input bit typed, input reading_t known);
    reading_t predicted;
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    level_a <= la;
    level_b <= lb;
    now_us <= now;
    do @(posedge clk); while (in_stall);
    predicted = predict_reading(k, la, lb, now);
    pending_readings.push_back(typed ? known : predicted);
    items_sent = items_sent + 1;
  endtask

  // Drop valid and hold until every predicted reading has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_register(input logic [qcv_pkg::CFG_IDX_W-1:0] idx,
                                input logic [qcv_pkg::CFG_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      qcv_pkg::REG_INVERT: invert_reg = value[0];
      qcv_pkg::REG_MPC:    mpc_reg = value;
      qcv_pkg::REG_ALPHA:  alpha_reg = value[16:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic inv, input logic [31:0] mpc, input logic [31:0] alpha);
    write_register(qcv_pkg::REG_INVERT, {31'd0, inv});
    write_register(qcv_pkg::REG_MPC, mpc);
    write_register(qcv_pkg::REG_ALPHA, alpha);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 37 : 0;
    recv_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 37 : 0;
  endtask

  task automatic add_item(input logic [qcv_pkg::KIND_W-1:0] k, input logic la, input logic lb,
                          input logic [31:0] now);
    stim_row_t row;
    row.op = ROW_ITEM;
    row.kind = k;
    row.lev_a = la;
    row.lev_b = lb;
    row.stamp = now;
    row.typed = 1'b0;
    row.known = '0;
    row.reg_index = '0;
    row.reg_value = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input logic [qcv_pkg::KIND_W-1:0] k, input logic la,
                           input logic lb, input logic [31:0] now, input logic [31:0] pos,
                           input logic [31:0] vel);
    add_item(k, la, lb, now);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].known = '{pos, vel, k == qcv_pkg::KIND_SAMPLE};
  endtask

  task automatic add_write(input logic [qcv_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    stim_row_t row;
    row = '{ROW_WRITE, '0, 1'b0, 1'b0, '0, 1'b0, '0, idx, value};
    directed_rows.push_back(row);
  endtask

  // Move the pins one x4 step forward or backward and send the edge
  task automatic quad_step(input bit forward);
    if (forward == (pin_a == pin_b)) begin
      pin_a = ~pin_a;
      offer_transaction(qcv_pkg::KIND_EDGE_A, pin_a, pin_b, $urandom, 1'b0, '0);
    end else begin
      pin_b = ~pin_b;
      offer_transaction(qcv_pkg::KIND_EDGE_B, pin_a, pin_b, $urandom, 1'b0, '0);
    end
  endtask

  // Mostly runs of clean edges closed by a sample, with noise and early samples
  task automatic run_phase(input int n_items, input bit pause_midway);
    int target;
    int pick;
    bit forward;
    bit paused;
    target = items_sent + n_items;
    paused = 1'b0;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        forward = 1'($urandom_range(1));
        repeat ($urandom_range(60)) quad_step(forward);
        pick = $urandom_range(99);
        if (pick < 70) stamp = stamp + $urandom_range(5000, 1000);
        else if (pick < 90) stamp = stamp + $urandom_range(200000, 5000);
        else if (pick < 95) stamp = stamp + SAMPLE_MIN_GAP;
        else stamp = $urandom;
        offer_transaction(qcv_pkg::KIND_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          stamp, 1'b0, '0);
      end else if (pick < 90) begin
        offer_transaction(qcv_pkg::KIND_W'($urandom_range(3)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), $urandom, 1'b0, '0);
      end else begin
        offer_transaction(qcv_pkg::KIND_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          stamp + $urandom_range(999), 1'b0, '0);
      end
      // Hold the sender until the block has answered everything
      if (pause_midway && !paused && items_sent >= target - n_items / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
  endtask

  initial begin
    // Directed table: edges, unknown kind, early and first samples, seeding,
    // averaging, timestamp wrap, inversion and register extremes
    add_known(qcv_pkg::KIND_EDGE_A, 1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    add_known(qcv_pkg::KIND_EDGE_A, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
    add_known(qcv_pkg::KIND_EDGE_B, 1'b1, 1'b1, 32'h0, 32'h1, 32'h0);
    add_known(qcv_pkg::KIND_EDGE_B, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0);
    add_known(KIND_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_known(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd0, 32'h0, 32'h0);
    add_known(qcv_pkg::KIND_SAMPLE, 1'b1, 1'b1, 32'd999, 32'h0, 32'h0);
    add_known(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b1, 32'd1000, 32'h0, 32'h0);
    add_known(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd2000, 32'h0, 32'h0);
    add_item(qcv_pkg::KIND_EDGE_A, 1'b1, 1'b0, 32'h0);
    add_item(qcv_pkg::KIND_EDGE_A, 1'b0, 1'b1, 32'h0);
    add_item(qcv_pkg::KIND_EDGE_B, 1'b0, 1'b0, 32'h0);
    add_item(qcv_pkg::KIND_EDGE_B, 1'b1, 1'b1, 32'h0);
    add_known(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd2999, 32'd4, 32'h0);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd4000);
    add_item(qcv_pkg::KIND_EDGE_B, 1'b0, 1'b1, 32'h0);
    add_item(qcv_pkg::KIND_EDGE_B, 1'b1, 1'b0, 32'h0);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b1, 1'b0, 32'd6000);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b1, 1'b0, 32'd7000);
    add_write(qcv_pkg::REG_INVERT, 32'd1);
    add_known(qcv_pkg::KIND_EDGE_A, 1'b1, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FF00);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'h0000_0400);
    add_write(qcv_pkg::REG_MPC, 32'hFFFF_FFFF);
    add_write(qcv_pkg::REG_ALPHA, 32'd65536);
    add_item(qcv_pkg::KIND_EDGE_A, 1'b1, 1'b0, 32'h0);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'h0000_0800);
    add_write(qcv_pkg::REG_ALPHA, 32'd0);
    add_item(qcv_pkg::KIND_EDGE_B, 1'b1, 1'b1, 32'h0);
    add_item(qcv_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'h0000_0C00);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    set_idling(IDLE_NONE);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_WRITE) begin
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        offer_transaction(directed_rows[i].kind, directed_rows[i].lev_a,
                          directed_rows[i].lev_b, directed_rows[i].stamp,
                          directed_rows[i].typed, directed_rows[i].known);
      end
    end

    // Random phases across register settings and idling patterns
    configure(1'b0, 32'd1000000, 32'd19661);
    set_idling(IDLE_NONE);
    run_phase(305, 1'b0);

    configure(1'b1, $urandom, $urandom_range(65536));
    set_idling(IDLE_SENDER);
    run_phase(305, 1'b0);

    configure(1'b1, 32'hFFFF_FFFF, 32'd65536);
    set_idling(IDLE_RECEIVER);
    run_phase(305, 1'b0);

    configure(1'b0, 32'd0, 32'd0);
    set_idling(IDLE_BOTH);
    run_phase(305, 1'b0);

    // Back up the output with a long receiver hold while the sender keeps going
    configure(1'b0, $urandom, $urandom_range(65536));
    set_idling(IDLE_NONE);
    stamp = 32'hFFFF_8000;
    hold_request = hold_request + 1;
    run_phase(305, 1'b0);

    configure(1'b1, $urandom_range(2000000), $urandom_range(65536));
    set_idling(IDLE_BOTH);
    run_phase(305, 1'b1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
